// ----- rtl/mbps_pkg.sv -----
// Shared types and constants of the masked byte pattern search unit.
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 6;
  localparam int ADDR_W   = 64;
  localparam int PLEN_W   = 7;
  localparam int CNT_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OP_W     = 2;
  localparam int S_DATA_W = 88;
  localparam int M_DATA_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_LIMIT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PAT_WRITE   = 2'd0,
    OP_SCAN_START  = 2'd1,
    OP_RANGE_START = 2'd2,
    OP_DATA        = 2'd3
  } op_t;

  // A decoded item as it waits between the front and the back.
  typedef struct packed {
    op_t               op;
    logic              idx_ok;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] value;
    logic              care;
    logic [ADDR_W-1:0] addr;
  } q_item_t;

endpackage

// ----- rtl/mbps_front.sv -----
// Front part: unpacks incoming items, checks the entry index and classifies the op.
`timescale 1ns / 1ps
module mbps_front #(
  parameter int PAT_MAX = 64
) (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mbps_pkg::OP_W-1:0]       s_tuser,
  input  logic [mbps_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                            q_push,
  input  logic                            q_ready,
  output mbps_pkg::q_item_t               q_item
);
  import mbps_pkg::*;

  logic [IDX_W-1:0]  entry_index;
  logic [BYTE_W-1:0] pattern_byte;
  logic              care;
  logic [ADDR_W-1:0] range_address;
  logic [BYTE_W-1:0] data_byte;

  assign entry_index   = s_tdata[5:0];
  assign pattern_byte  = s_tdata[13:6];
  assign care          = s_tdata[14];
  assign range_address = s_tdata[78:15];
  assign data_byte     = s_tdata[86:79];

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  always_comb begin
    q_item.op     = op_t'(s_tuser);
    q_item.idx_ok = int'(entry_index) < PAT_MAX;
    q_item.idx    = entry_index;
    // Pattern writes and data bytes share one byte slot in the queue.
    q_item.value  = (op_t'(s_tuser) == OP_DATA) ? data_byte : pattern_byte;
    q_item.care   = care;
    q_item.addr   = range_address;
  end

endmodule

// ----- rtl/mbps_queue.sv -----
// Short queue of decoded items between the front and the back.
`timescale 1ns / 1ps
module mbps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              in_ready,
  input  mbps_pkg::q_item_t in_item,
  output logic              out_valid,
  input  logic              pop,
  output mbps_pkg::q_item_t out_item
);
  import mbps_pkg::*;

  q_item_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/mbps_back.sv -----
// Back part: pattern store, byte window, parallel compare, match counting and result register.
`timescale 1ns / 1ps
module mbps_back #(
  parameter int PAT_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_fire,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              q_valid,
  input  mbps_pkg::q_item_t                 q_item,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mbps_pkg::M_DATA_W-1:0]     m_tdata,
  output logic                              m_tuser
);
  import mbps_pkg::*;

  localparam int LW = $clog2(PAT_MAX + 1);
  localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

  // Pattern kept in reversed order (entry j at PAT_MAX-1-j) and a copy aligned to the window.
  logic [BYTE_W-1:0] rpat  [PAT_MAX];
  logic              rcare [PAT_MAX];
  logic [BYTE_W-1:0] apat  [PAT_MAX];
  logic              acare [PAT_MAX];
  logic [BYTE_W-1:0] win   [PAT_MAX];

  logic [PLEN_W-1:0] plen;
  logic [CNT_W-1:0]  maxr;
  logic              realign;
  logic [LW-1:0]     fill;
  logic [ADDR_W-1:0] next_addr;
  logic [CNT_W-1:0]  match_count;
  logic              limit_hit;
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic              out_trunc;

  logic [LW-1:0]             len_eff;
  logic [LW-1:0]             shift_amt;
  logic [PAT_MAX*BYTE_W-1:0] rpat_vec;
  logic [PAT_MAX*BYTE_W-1:0] apat_vec;
  logic [PAT_MAX-1:0]        rcare_vec;
  logic [PAT_MAX-1:0]        acare_vec;
  logic [BYTE_W-1:0]         win_new [PAT_MAX];
  logic [PAT_MAX-1:0]        lane_bad;
  logic [LW-1:0]             fill_new;
  logic [CNT_W-1:0]          lim;
  logic                      is_data;
  logic                      hit;
  logic                      emit_addr;
  logic                      emit_trunc;
  logic                      has_result;
  logic                      out_space;
  logic                      go;
  logic                      in_len;
  logic [AW-1:0]             rpa;
  logic [AW-1:0]             apa;
  logic [ADDR_W-1:0]         start_addr;

  // Pattern length clamped to 1..PAT_MAX.
  always_comb begin
    if (plen == '0) begin
      len_eff = LW'(1);
    end else if (int'(plen) > PAT_MAX) begin
      len_eff = LW'(PAT_MAX);
    end else begin
      len_eff = LW'(plen);
    end
  end

  // Aligned lane p needs entry len-1-p, which sits at reversed slot p + (PAT_MAX - len).
  assign shift_amt = LW'(PAT_MAX) - len_eff;

  always_comb begin
    for (int p = 0; p < PAT_MAX; p++) begin
      rpat_vec[p*BYTE_W +: BYTE_W] = rpat[p];
      rcare_vec[p]                 = rcare[p];
    end
  end

  assign apat_vec  = rpat_vec >> {shift_amt, 3'b000};
  assign acare_vec = rcare_vec >> shift_amt;

  assign is_data = q_item.op == OP_DATA;

  // Window after the new byte shifts in; entry 0 holds the newest byte.
  always_comb begin
    win_new[0] = q_item.value;
    for (int p = 1; p < PAT_MAX; p++) begin
      win_new[p] = win[p-1];
    end
    for (int p = 0; p < PAT_MAX; p++) begin
      lane_bad[p] = (p < int'(len_eff)) && acare[p] && (win_new[p] != apat[p]);
    end
  end

  assign fill_new   = (int'(fill) == PAT_MAX) ? fill : fill + LW'(1);
  assign lim        = (maxr == '0) ? CNT_W'(1) : maxr;
  assign hit        = is_data && (fill_new >= len_eff) && !(|lane_bad);
  assign emit_addr  = hit && (match_count < lim);
  assign emit_trunc = hit && !(match_count < lim) && !limit_hit;
  assign has_result = emit_addr || emit_trunc;
  assign out_space  = !out_valid || m_tready;
  assign go         = q_valid && !realign && !cfg_fire && (!has_result || out_space);
  assign q_pop      = go;

  assign start_addr = next_addr - ADDR_W'(len_eff - LW'(1));

  assign in_len = int'(q_item.idx) < int'(len_eff);
  assign rpa    = AW'(PAT_MAX - 1 - int'(q_item.idx));
  assign apa    = AW'(int'(len_eff) - 1 - int'(q_item.idx));

  // Pattern stores and window: no reset; entries must be written before read (not enforced).
  always_ff @(posedge clk) begin
    if (realign) begin
      for (int p = 0; p < PAT_MAX; p++) begin
        apat[p]  <= apat_vec[p*BYTE_W +: BYTE_W];
        acare[p] <= acare_vec[p];
      end
    end else if (go && q_item.op == OP_PAT_WRITE && q_item.idx_ok) begin
      rpat[rpa]  <= q_item.value;
      rcare[rpa] <= q_item.care;
      if (in_len) begin
        apat[apa]  <= q_item.value;
        acare[apa] <= q_item.care;
      end
    end
    if (go && is_data) begin
      for (int p = 0; p < PAT_MAX; p++) begin
        win[p] <= win_new[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen        <= PLEN_W'(1);
      maxr        <= CNT_W'(1);
      realign     <= 1'b0;
      fill        <= '0;
      next_addr   <= '0;
      match_count <= '0;
      limit_hit   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      realign <= 1'b0;
      if (cfg_fire) begin
        if (cfg_index == CFG_PAT_LENGTH) begin
          plen    <= cfg_data[PLEN_W-1:0];
          realign <= 1'b1;
        end else if (cfg_index == CFG_RESULT_LIMIT) begin
          maxr <= cfg_data;
        end
      end
      if (go) begin
        case (q_item.op)
          OP_SCAN_START: begin
            match_count <= '0;
            limit_hit   <= 1'b0;
          end
          OP_RANGE_START: begin
            next_addr <= q_item.addr;
            fill      <= '0;
          end
          OP_DATA: begin
            fill      <= fill_new;
            next_addr <= next_addr + ADDR_W'(1);
            if (emit_addr) begin
              match_count <= match_count + CNT_W'(1);
            end
            if (emit_trunc) begin
              limit_hit <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (go && has_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_result) begin
      out_addr  <= emit_addr ? start_addr : '0;
      out_trunc <= emit_trunc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_addr;
  assign m_tuser  = out_trunc;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= PAT_MAX)
    else $error("window fill count exceeds the window depth");

  a_realign_once: assert property (@(posedge clk) disable iff (rst)
    realign && !cfg_fire |=> !realign)
    else $error("realignment lasted more than one cycle");

  a_trunc_sets_limit: assert property (@(posedge clk) disable iff (rst)
    go && emit_trunc |=> limit_hit && m_tvalid && m_tuser)
    else $error("truncation result did not latch the limit flag");

  a_limit_needs_count: assert property (@(posedge clk) disable iff (rst)
    limit_hit |-> match_count != '0)
    else $error("limit flag set with a zero match count");

endmodule

// ----- rtl/masked_byte_pattern_search_unit.sv -----
// Top level of the masked byte pattern search unit.
`timescale 1ns / 1ps
// A data byte that completes a match is queued, then popped by the back part, which
// registers its result onto m_tvalid. Throughput: one item per cycle with a combinational
// window compare, while no held result, config write or pattern length realign stalls it.
// Reset (rst, synchronous) clears the queue, counters, window fill, address and output
// register valid flag; both configuration registers return to 1.
module masked_byte_pattern_search_unit #(
  parameter int PAT_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: entry_index[5:0], pattern_byte[7:0], care, range_address[63:0],
  // data_byte[7:0], then one zero pad bit.
  input  logic [mbps_pkg::S_DATA_W-1:0]   s_tdata,
  // s_tuser: op[1:0].
  input  logic [mbps_pkg::OP_W-1:0]       s_tuser,
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: match_address[63:0].
  output logic [mbps_pkg::M_DATA_W-1:0]   m_tdata,
  // m_tuser: truncated.
  output logic                            m_tuser,
  // Configuration writes: index 0 is the pattern length, index 1 is the result limit.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbps_pkg::*;

  q_item_t front_item;
  q_item_t back_item;
  logic    front_push;
  logic    queue_ready;
  logic    queue_valid;
  logic    back_pop;

  // Configuration is always taken; the back part holds off items in a write or realign.
  assign cfg_ready = 1'b1;

  // The front unpacks the stream item and decides what kind of work it is.
  mbps_front #(
    .PAT_MAX (PAT_MAX)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_push   (front_push),
    .q_ready  (queue_ready),
    .q_item   (front_item)
  );

  // The queue lets the input side keep flowing while the back waits on the result register.
  mbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .in_ready  (queue_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .pop       (back_pop),
    .out_item  (back_item)
  );

  // The back holds the pattern and window, compares all lanes at once and emits results.
  mbps_back #(
    .PAT_MAX (PAT_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (queue_valid),
    .q_item    (back_item),
    .q_pop     (back_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
